FILE: hdl/htd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htd_pkg
// Shared constants and codes for the Huffman tree decoder core.
// ----------------------------------------------------------------------------
package htd_pkg;

    // Default tree size and symbol width
    localparam int MAX_LEAVES_DEF  = 256;
    localparam int SYMBOL_BITS_DEF = 8;

    // Action codes carried by an input item
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_DECODE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_SYMBOL     = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_LOAD_ERR   = 2'd2;
    localparam logic [1:0] ST_ONE_LEAF   = 2'd3;

    // What the second pipeline stage does with its item
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,   // no result (clear, good load, idle code, out-of-range branch)
        KIND_IMM  = 2'd1,   // status decided at transfer time
        KIND_WALK = 2'd2    // node read issued, leaf test on read data
    } htd_kind_t;

endpackage : htd_pkg
`default_nettype wire

FILE: hdl/huffman_tree_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_decoder_core
// Loads a pre-order flattened Huffman tree and decodes message bits by a
// bit-serial walk from the root.
// ----------------------------------------------------------------------------
// The core takes one item per clock while item_ready is high: a load, a clear
// or one message bit. A result (decoded symbol or error status) passes the
// stage-two registers and waits in a three-entry output queue that offers it
// on the result channel, so input and output stall independently. Each
// message bit costs one read of the node memories;
// the next bit's branch target is forwarded straight from that read data, which
// is the loop that sets the one-bit-per-cycle walk while input is accepted. The
// node store is split in two memories: node_mem holds the leaf flag and
// symbol, link_mem holds the one-child link of every internal node. While a
// tree is being loaded, the link field of an internal node still waiting for
// its one child holds the index of the open node below it, so link_mem
// doubles as the stack of open nodes. Node memory needs no clearing pass after
// reset; a clear action resets the node count, depth and complete flag.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_core #(
    parameter int MAX_LEAVES  = htd_pkg::MAX_LEAVES_DEF,
    parameter int SYMBOL_BITS = htd_pkg::SYMBOL_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input item channel
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic [1:0]             action,
    input  wire logic                   node_is_internal,
    input  wire logic [SYMBOL_BITS-1:0] leaf_symbol,
    input  wire logic                   message_bit,
    // result channel
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic [SYMBOL_BITS-1:0]      symbol,
    output logic [1:0]                  status
);

    localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1;
    localparam int IDX_W      = $clog2(NODE_DEPTH);
    localparam int LINK_W     = $clog2(NODE_DEPTH + 1);
    localparam int DEPTH_W    = $clog2(MAX_LEAVES + 1);
    localparam int QDEPTH     = 3;

    localparam logic [LINK_W-1:0]  NODE_LIMIT  = LINK_W'(NODE_DEPTH);
    localparam logic [DEPTH_W-1:0] STACK_LIMIT = DEPTH_W'(MAX_LEAVES);

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [SYMBOL_BITS:0] node_mem [NODE_DEPTH];
    logic [LINK_W-1:0]    link_mem [NODE_DEPTH];

    logic                 node_we;
    logic [IDX_W-1:0]     node_waddr;
    logic [SYMBOL_BITS:0] node_wdata;
    logic                 link_we;
    logic [IDX_W-1:0]     link_waddr;
    logic [LINK_W-1:0]    link_wdata;
    logic [IDX_W-1:0]     rd_addr;
    logic [SYMBOL_BITS:0] node_q;
    logic [LINK_W-1:0]    link_q;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    logic [LINK_W-1:0]  loaded_reg,  loaded_next;
    logic [DEPTH_W-1:0] depth_reg,   depth_next;
    logic [IDX_W-1:0]   top_reg,     top_next;
    logic [IDX_W-1:0]   second_reg,  second_next;
    logic               sec_mem_reg, sec_mem_next;
    logic               complete_reg, complete_next;
    logic               root_leaf_reg, root_leaf_next;
    logic [LINK_W-1:0]  root_link_reg, root_link_next;
    logic               at_root_reg, at_root_next;
    logic [IDX_W-1:0]   pos_reg,     pos_next;
    logic [LINK_W-1:0]  link_reg,    link_next;

    logic               s2_valid_reg, s2_valid_next;
    htd_pkg::htd_kind_t s2_kind_reg,  s2_kind_next;
    logic [1:0]         s2_status_reg, s2_status_next;
    logic [IDX_W-1:0]   s2_addr_reg,  s2_addr_next;

    // output queue
    logic [SYMBOL_BITS-1:0] q_sym_reg    [QDEPTH];
    logic [1:0]             q_status_reg [QDEPTH];
    logic [1:0]             q_wr_reg, q_rd_reg, q_cnt_reg;

    // ------------------------------------------------------------------
    // Node memory ports: one write, one registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_q <= node_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Forwarded walk position and stack second entry
    // ------------------------------------------------------------------
    logic               s2_walk;
    logic               q_leaf;
    logic [IDX_W-1:0]   cur_pos;
    logic [LINK_W-1:0]  cur_link;
    logic               cur_root;
    logic [IDX_W-1:0]   second_eff;

    assign s2_walk = s2_valid_reg && (s2_kind_reg == htd_pkg::KIND_WALK);
    assign q_leaf  = node_q[SYMBOL_BITS];

    always_comb
    begin
        cur_root = at_root_reg;
        cur_pos  = pos_reg;
        cur_link = link_reg;
        if (s2_walk)
        begin
            cur_root = q_leaf;
            cur_pos  = s2_addr_reg;
            cur_link = link_q;
        end
        if (cur_root)
        begin
            cur_pos  = '0;
            cur_link = root_link_reg;
        end
    end

    assign second_eff = sec_mem_reg ? link_q[IDX_W-1:0] : second_reg;

    // ------------------------------------------------------------------
    // Input acceptance: credit for queue slots plus the item in stage two
    // ------------------------------------------------------------------
    logic       in_xfer;
    logic [2:0] credit_used;

    assign credit_used = {1'b0, q_cnt_reg} + {2'b00, s2_valid_reg};
    assign item_ready  = (credit_used < 3'(QDEPTH));
    assign in_xfer     = item_valid && item_ready;

    // ------------------------------------------------------------------
    // Stage one: load, clear and walk step
    // ------------------------------------------------------------------
    logic [LINK_W-1:0] step_target;
    logic [IDX_W-1:0]  load_idx;

    assign load_idx    = loaded_reg[IDX_W-1:0];
    assign step_target = message_bit ? cur_link : (LINK_W'(cur_pos) + LINK_W'(1));

    always_comb
    begin
        loaded_next    = loaded_reg;
        depth_next     = depth_reg;
        top_next       = top_reg;
        second_next    = second_eff;
        sec_mem_next   = 1'b0;
        complete_next  = complete_reg;
        root_leaf_next = root_leaf_reg;
        root_link_next = root_link_reg;
        at_root_next   = cur_root;
        pos_next       = cur_pos;
        link_next      = cur_link;

        s2_valid_next  = in_xfer;
        s2_kind_next   = htd_pkg::KIND_NONE;
        s2_status_next = htd_pkg::ST_SYMBOL;
        s2_addr_next   = s2_addr_reg;

        node_we    = 1'b0;
        node_waddr = load_idx;
        node_wdata = {~node_is_internal,
                      node_is_internal ? {SYMBOL_BITS{1'b0}} : leaf_symbol};
        link_we    = 1'b0;
        link_waddr = load_idx;
        link_wdata = LINK_W'(top_reg);
        rd_addr    = second_eff;

        if (in_xfer)
        begin
            case (action)
                htd_pkg::ACT_CLEAR:
                begin
                    loaded_next   = '0;
                    depth_next    = '0;
                    complete_next = 1'b0;
                    at_root_next  = 1'b1;
                end
                htd_pkg::ACT_LOAD:
                begin
                    if (complete_reg || (loaded_reg >= NODE_LIMIT) ||
                        (node_is_internal && (depth_reg >= STACK_LIMIT)))
                    begin
                        s2_kind_next   = htd_pkg::KIND_IMM;
                        s2_status_next = htd_pkg::ST_LOAD_ERR;
                    end
                    else
                    begin
                        node_we     = 1'b1;
                        loaded_next = loaded_reg + LINK_W'(1);
                        if (load_idx == '0)
                        begin
                            root_leaf_next = ~node_is_internal;
                        end
                        if (node_is_internal)
                        begin
                            // push: link field points at the open node below
                            link_we     = 1'b1;
                            second_next = top_reg;
                            top_next    = load_idx;
                            depth_next  = depth_reg + DEPTH_W'(1);
                        end
                        else if (depth_reg == '0)
                        begin
                            complete_next = 1'b1;
                        end
                        else
                        begin
                            // pop: parent's one child is the next free entry
                            link_we      = 1'b1;
                            link_waddr   = top_reg;
                            link_wdata   = loaded_reg + LINK_W'(1);
                            top_next     = second_eff;
                            rd_addr      = second_eff;
                            sec_mem_next = 1'b1;
                            depth_next   = depth_reg - DEPTH_W'(1);
                            if (top_reg == '0)
                            begin
                                root_link_next = loaded_reg + LINK_W'(1);
                            end
                        end
                    end
                end
                htd_pkg::ACT_DECODE:
                begin
                    if (!complete_reg)
                    begin
                        s2_kind_next   = htd_pkg::KIND_IMM;
                        s2_status_next = htd_pkg::ST_INCOMPLETE;
                    end
                    else if (root_leaf_reg)
                    begin
                        s2_kind_next   = htd_pkg::KIND_IMM;
                        s2_status_next = htd_pkg::ST_ONE_LEAF;
                    end
                    else if (step_target >= NODE_LIMIT)
                    begin
                        at_root_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr      = step_target[IDX_W-1:0];
                        s2_kind_next = htd_pkg::KIND_WALK;
                        s2_addr_next = step_target[IDX_W-1:0];
                    end
                end
                default:
                begin
                    s2_kind_next = htd_pkg::KIND_NONE;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            depth_reg     <= '0;
            sec_mem_reg   <= 1'b0;
            complete_reg  <= 1'b0;
            at_root_reg   <= 1'b1;
            s2_valid_reg  <= 1'b0;
            s2_kind_reg   <= htd_pkg::KIND_NONE;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            depth_reg     <= depth_next;
            sec_mem_reg   <= sec_mem_next;
            complete_reg  <= complete_next;
            at_root_reg   <= at_root_next;
            s2_valid_reg  <= s2_valid_next;
            s2_kind_reg   <= s2_kind_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        second_reg    <= second_next;
        root_leaf_reg <= root_leaf_next;
        root_link_reg <= root_link_next;
        pos_reg       <= pos_next;
        link_reg      <= link_next;
        s2_status_reg <= s2_status_next;
        s2_addr_reg   <= s2_addr_next;
    end

    // ------------------------------------------------------------------
    // Stage two: form the result and push it into the output queue
    // ------------------------------------------------------------------
    logic                   res_push;
    logic [SYMBOL_BITS-1:0] res_sym;
    logic [1:0]             res_status;
    logic                   res_pop;

    assign res_push   = s2_valid_reg &&
                        ((s2_kind_reg == htd_pkg::KIND_IMM) || (s2_walk && q_leaf));
    assign res_sym    = s2_walk ? node_q[SYMBOL_BITS-1:0] : '0;
    assign res_status = s2_walk ? htd_pkg::ST_SYMBOL : s2_status_reg;
    assign res_pop    = result_valid && result_ready;

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_sym_reg[q_wr_reg]    <= res_sym;
            q_status_reg[q_wr_reg] <= res_status;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (res_push)
            begin
                q_wr_reg <= (q_wr_reg == 2'(QDEPTH - 1)) ? 2'd0 : q_wr_reg + 2'd1;
            end
            if (res_pop)
            begin
                q_rd_reg <= (q_rd_reg == 2'(QDEPTH - 1)) ? 2'd0 : q_rd_reg + 2'd1;
            end
            case ({res_push, res_pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + 2'd1;
                2'b01:   q_cnt_reg <= q_cnt_reg - 2'd1;
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
    end

    assign result_valid = (q_cnt_reg != '0);
    assign symbol       = q_sym_reg[q_rd_reg];
    assign status       = q_status_reg[q_rd_reg];

endmodule : huffman_tree_decoder_core
`default_nettype wire
